// ===== rtl/core/ddtm_pkg.sv =====
// ----------------------------------------------------------------------------
// ddtm_pkg
// Shared types and constants for the differential-drive teleop mixer: the
// item and result layouts, register indexes and wheel direction codes.
// ----------------------------------------------------------------------------
package ddtm_pkg;

  // Widths of the data items
  localparam int unsigned AXIS_W  = 16;
  localparam int unsigned GAIN_W  = 10;
  localparam int unsigned SPEED_W = 10;
  localparam int unsigned DIR_W   = 3;
  localparam int unsigned CFG_IDX_W = 3;

  // Fraction bits of joystick axes (Q1.15) and velocities (Q8.8)
  localparam int unsigned JOY_FRAC = 15;
  localparam int unsigned VEL_FRAC = 8;

  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

  // Wheel direction codes
  localparam logic [DIR_W-1:0] DIR_STOP = 3'd0;
  localparam logic [DIR_W-1:0] DIR_A    = 3'd6;  // left forward, right reverse
  localparam logic [DIR_W-1:0] DIR_B    = 3'd5;  // left reverse, right forward

  // Item kinds
  localparam logic KIND_JOY = 1'b0;
  localparam logic KIND_VEL = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THROTTLE_GAIN  = 3'd0,
    REG_STEER_GAIN     = 3'd1,
    REG_LINEAR_GAIN    = 3'd2,
    REG_ANGULAR_GAIN   = 3'd3,
    REG_STEER_DEADBAND = 3'd4
  } reg_index_t;

  // Register reset values
  localparam logic [GAIN_W-1:0] THROTTLE_GAIN_RST  = 10'd250;
  localparam logic [GAIN_W-1:0] STEER_GAIN_RST     = 10'd150;
  localparam logic [GAIN_W-1:0] LINEAR_GAIN_RST    = 10'd150;
  localparam logic [GAIN_W-1:0] ANGULAR_GAIN_RST   = 10'd282;
  localparam logic [GAIN_W-1:0] STEER_DEADBAND_RST = 10'd5;

  typedef struct packed {
    logic                     kind;
    logic signed [AXIS_W-1:0] right_trigger;
    logic signed [AXIS_W-1:0] left_trigger;
    logic signed [AXIS_W-1:0] steer_axis;
    logic                     btn_normal_speed;
    logic                     btn_slow_speed;
    logic                     btn_manual;
    logic                     btn_auto;
    logic signed [AXIS_W-1:0] linear_vel;
    logic signed [AXIS_W-1:0] angular_vel;
  } cmd_t;

  typedef struct packed {
    logic [SPEED_W-1:0] left_speed;
    logic [DIR_W-1:0]   left_dir;
    logic [SPEED_W-1:0] right_speed;
    logic [DIR_W-1:0]   right_dir;
    logic               auto_active;
    logic               slow_active;
    logic               is_calibrated;
  } res_t;

endpackage

// ===== rtl/core/diff_drive_teleop_mixer.sv =====
// ----------------------------------------------------------------------------
// diff_drive_teleop_mixer
// Arcade mixer for a differential drive: joystick events and velocity
// commands update held wheel speeds, direction codes and mode flags.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the result side is not
// stalled, and returns one result per item. An item is captured in an
// input register; when it advances, two shared 17x11 and 16x11 signed
// multipliers, the mix adders and the magnitude logic update the wheel and
// mode state and load the result register. A stall on the result side holds
// the result register and then the input register, and only then stalls the
// command side. Configuration writes go straight to the gain and deadband
// registers and take effect on the next item that is mixed.
module diff_drive_teleop_mixer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_valid,
  output logic                                 cmd_stall,
  input  ddtm_pkg::cmd_t                       cmd,
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output ddtm_pkg::res_t                       res,
  input  logic                                 cfg_we,
  input  logic [ddtm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ddtm_pkg::GAIN_W-1:0]          cfg_data
);
  import ddtm_pkg::*;

  localparam int unsigned OPA_W  = AXIS_W + 1;          // trigger difference
  localparam int unsigned PROD_W = OPA_W + GAIN_W + 1;  // signed product
  localparam int unsigned MIX_W  = PROD_W + 1;          // sum of two products

  // Configuration registers
  logic [GAIN_W-1:0] throttle_gain, steer_gain, linear_gain, angular_gain;
  logic [GAIN_W-1:0] steer_deadband;

  // Input register
  logic s1_valid;
  cmd_t s1;

  // Block state
  logic [SPEED_W-1:0] left_mag, right_mag;
  logic [DIR_W-1:0]   left_code, right_code;
  logic calibrated_flag, slow_flag, auto_flag, command_seen;

  logic out_free, advance, cmd_accept;

  // Datapath
  logic signed [OPA_W-1:0]  opa;
  logic signed [AXIS_W-1:0] opb;
  logic signed [GAIN_W:0]   gain_a, gain_b;
  logic signed [PROD_W-1:0] prod_a, prod_b, turn;
  logic [PROD_W-1:0]        abs_turn, deadband_q;
  logic signed [MIX_W-1:0]  mix_l, mix_r;
  logic slow_next, auto_next, cal_next, wheel_en;
  logic [SPEED_W-1:0] left_mag_next, right_mag_next;
  logic [DIR_W-1:0]   left_code_next, right_code_next;

  // Magnitude of a mixed value: truncate to whole units, halve, saturate
  function automatic logic [SPEED_W-1:0] wheel_mag(logic signed [MIX_W-1:0] v,
                                                   logic vel, logic half);
    logic [MIX_W-1:0] a;
    logic [MIX_W-1:0] m;
    a = v[MIX_W-1] ? (~v + 1'b1) : v;
    m = vel ? (a >> VEL_FRAC) : (a >> JOY_FRAC);
    if (half) m = m >> 1;
    return (m > MIX_W'(SPEED_MAX)) ? SPEED_MAX : m[SPEED_W-1:0];
  endfunction

  // Direction of a mixed value; velocity values under one unit stop
  function automatic logic [DIR_W-1:0] wheel_dir(logic signed [MIX_W-1:0] v,
                                                 logic vel,
                                                 logic [DIR_W-1:0] pos,
                                                 logic [DIR_W-1:0] neg);
    logic [MIX_W-1:0] a;
    logic [MIX_W-1:0] m;
    a = v[MIX_W-1] ? (~v + 1'b1) : v;
    m = a >> VEL_FRAC;
    if (v == '0 || (vel && m == '0)) return DIR_STOP;
    return v[MIX_W-1] ? neg : pos;
  endfunction

  // Handshake: the input register moves on when the result slot is free
  assign out_free   = !res_valid || !res_stall;
  assign advance    = s1_valid && out_free;
  assign cmd_stall  = s1_valid && !out_free;
  assign cmd_accept = cmd_valid && !cmd_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      throttle_gain  <= THROTTLE_GAIN_RST;
      steer_gain     <= STEER_GAIN_RST;
      linear_gain    <= LINEAR_GAIN_RST;
      angular_gain   <= ANGULAR_GAIN_RST;
      steer_deadband <= STEER_DEADBAND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THROTTLE_GAIN:  throttle_gain  <= cfg_data;
        REG_STEER_GAIN:     steer_gain     <= cfg_data;
        REG_LINEAR_GAIN:    linear_gain    <= cfg_data;
        REG_ANGULAR_GAIN:   angular_gain   <= cfg_data;
        REG_STEER_DEADBAND: steer_deadband <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      s1 <= cmd;
    end
  end

  // Share the multipliers between joystick and velocity mixing
  always_comb begin
    if (s1.kind == KIND_VEL) begin
      opa    = OPA_W'(s1.linear_vel);
      opb    = s1.angular_vel;
      gain_a = $signed({1'b0, linear_gain});
      gain_b = $signed({1'b0, angular_gain});
    end else begin
      opa    = OPA_W'(s1.right_trigger) - OPA_W'(s1.left_trigger);
      opb    = s1.steer_axis;
      gain_a = $signed({1'b0, throttle_gain});
      gain_b = $signed({1'b0, steer_gain});
    end
  end

  assign prod_a = PROD_W'(opa) * PROD_W'(gain_a);
  assign prod_b = PROD_W'(opb) * PROD_W'(gain_b);

  // Zero the joystick turn inside the deadband
  assign abs_turn   = prod_b[PROD_W-1] ? PROD_W'(-prod_b) : PROD_W'(prod_b);
  assign deadband_q = PROD_W'(steer_deadband) << JOY_FRAC;
  assign turn = (s1.kind == KIND_JOY && abs_turn < deadband_q) ? '0 : prod_b;

  assign mix_l = MIX_W'(prod_a) - MIX_W'(turn);
  assign mix_r = MIX_W'(prod_a) + MIX_W'(turn);

  // Next mode flags; slow wins over normal, auto needs a seen command
  always_comb begin
    slow_next = slow_flag;
    auto_next = auto_flag;
    cal_next  = calibrated_flag;
    if (s1.kind == KIND_JOY) begin
      if (s1.btn_normal_speed) slow_next = 1'b0;
      if (s1.btn_slow_speed)   slow_next = 1'b1;
      if (s1.btn_manual)       auto_next = 1'b0;
      if (s1.btn_auto && command_seen) auto_next = 1'b1;
      if (s1.right_trigger == {1'b1, {(AXIS_W-1){1'b0}}} &&
          s1.left_trigger  == {1'b1, {(AXIS_W-1){1'b0}}}) begin
        cal_next = 1'b1;
      end
    end
  end

  // Wheels move on commands in auto mode, on calibrated joystick in manual
  assign wheel_en = (s1.kind == KIND_VEL) ? auto_flag : (!auto_next && cal_next);

  always_comb begin
    left_mag_next   = wheel_mag(mix_l, s1.kind, (s1.kind == KIND_JOY) && slow_next);
    right_mag_next  = wheel_mag(mix_r, s1.kind, (s1.kind == KIND_JOY) && slow_next);
    left_code_next  = wheel_dir(mix_l, s1.kind, DIR_A, DIR_B);
    right_code_next = wheel_dir(mix_r, s1.kind, DIR_B, DIR_A);
  end

  // Update the state
  always_ff @(posedge clk) begin
    if (rst) begin
      left_mag        <= '0;
      right_mag       <= '0;
      left_code       <= DIR_STOP;
      right_code      <= DIR_STOP;
      calibrated_flag <= 1'b0;
      slow_flag       <= 1'b0;
      auto_flag       <= 1'b0;
      command_seen    <= 1'b0;
    end else if (advance) begin
      slow_flag       <= slow_next;
      auto_flag       <= auto_next;
      calibrated_flag <= cal_next;
      if (s1.kind == KIND_VEL) command_seen <= 1'b1;
      if (wheel_en) begin
        left_mag   <= left_mag_next;
        right_mag  <= right_mag_next;
        left_code  <= left_code_next;
        right_code <= right_code_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.left_speed    <= wheel_en ? left_mag_next   : left_mag;
      res.left_dir      <= wheel_en ? left_code_next  : left_code;
      res.right_speed   <= wheel_en ? right_mag_next  : right_mag;
      res.right_dir     <= wheel_en ? right_code_next : right_code;
      res.auto_active   <= auto_next;
      res.slow_active   <= slow_next;
      res.is_calibrated <= cal_next;
    end
  end

  // Auto mode is only ever granted after a velocity command
  a_auto_needs_cmd: assert property (@(posedge clk) disable iff (rst)
    $rose(auto_flag) |-> $past(command_seen))
    else $error("auto mode entered without a seen command");

  // Calibration is sticky
  a_cal_sticky: assert property (@(posedge clk) disable iff (rst)
    !$fell(calibrated_flag))
    else $error("calibration flag cleared");

  // A stopped left wheel has zero speed
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.left_dir == DIR_STOP) |-> (res.left_speed == '0))
    else $error("left wheel stopped with nonzero speed");

endmodule
